FILE: rtl/cascaded_biquad_iir_filter_assert.svh
// Assertion macros used by the filter RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef CASCADED_BIQUAD_IIR_FILTER_ASSERT_SVH
`define CASCADED_BIQUAD_IIR_FILTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CBQ_ASSERT_IMPL(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CBQ_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

FILE: rtl/cbq_pkg.sv
package cbq_pkg;

  // Build-time sizing.
  localparam int NUM_SECTIONS = 2;
  localparam int SAMPLE_WIDTH = 16;

  // Fixed-point formats: samples Q4.x, coefficients Q2.29, delays Q15.16.
  localparam int SAMPLE_FRAC = SAMPLE_WIDTH - 5;
  localparam int UP_SHIFT    = (SAMPLE_FRAC <= 16) ? (16 - SAMPLE_FRAC) : 0;
  localparam int DN_SHIFT    = (SAMPLE_FRAC > 16) ? (SAMPLE_FRAC - 16) : 0;
  localparam int COEF_W      = 32;
  localparam int DATA_W      = 32;
  localparam int COEF_FRAC   = 29;
  localparam int PROD_W      = COEF_W + DATA_W;
  localparam int ACC_W       = PROD_W + 3;

  // Coefficient slots within a section.
  localparam int COEF_SLOTS = 5;
  localparam int NCOEF      = NUM_SECTIONS * COEF_SLOTS;
  localparam int COEF_AW    = $clog2(NCOEF);
  localparam int COEF_IDX_W = 6;

  localparam logic [COEF_AW-1:0] SLOT_B0 = COEF_AW'(0);
  localparam logic [COEF_AW-1:0] SLOT_B1 = COEF_AW'(1);
  localparam logic [COEF_AW-1:0] SLOT_B2 = COEF_AW'(2);
  localparam logic [COEF_AW-1:0] SLOT_A1 = COEF_AW'(3);
  localparam logic [COEF_AW-1:0] SLOT_A2 = COEF_AW'(4);

  // Delay slots within a section.
  localparam int SEC_W  = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
  localparam int DLY_AW = SEC_W + 2;

  localparam logic [1:0] DLY_X1 = 2'd0;
  localparam logic [1:0] DLY_X2 = 2'd1;
  localparam logic [1:0] DLY_Y1 = 2'd2;
  localparam logic [1:0] DLY_Y2 = 2'd3;

  // Configuration port.
  localparam int CNT_W  = 4;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = SAMPLE_WIDTH;

  localparam logic [CFG_IW-1:0] CFG_SECTIONS = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_OUT_MIN  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_OUT_MAX  = 2'd2;

  localparam logic [CNT_W-1:0] SECTIONS_RESET = 4'd2;
  localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MIN_RESET = SAMPLE_WIDTH'(-20480);
  localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MAX_RESET = SAMPLE_WIDTH'(20480);

  // Item operations.
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  // Built-in coefficient table, rounded to nearest in Q2.29.
  localparam int BASE_LEN = 10;
  localparam logic signed [COEF_W-1:0] BASE_COEF [BASE_LEN] = '{
    32'sd536870912, 32'sd536865543, 32'sd0, -32'sd473396664, 32'sd0,
    32'sd117457, 32'sd234908, 32'sd117457, -32'sd1002552741, 32'sd473627519
  };
  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(64'sd1 <<< COEF_FRAC);

  typedef logic signed [COEF_W-1:0] coef_tbl_t [NCOEF];

  // Sections beyond the built-in table start as identity.
  function automatic coef_tbl_t build_coef_init();
    coef_tbl_t tbl;
    for (int i = 0; i < NCOEF; i++) begin
      if (i < BASE_LEN) begin
        tbl[i] = BASE_COEF[i];
      end else if ((i % COEF_SLOTS) == 0) begin
        tbl[i] = COEF_ONE;
      end else begin
        tbl[i] = '0;
      end
    end
    return tbl;
  endfunction

  localparam coef_tbl_t COEF_INIT = build_coef_init();

  // Channel payloads.
  typedef struct packed {
    logic                           operation;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic [COEF_IDX_W-1:0]          coef_index;
    logic signed [COEF_W-1:0]       coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           clipped;
  } out_item_t;

  // Accumulator control from the sequencer to the MAC.
  typedef struct packed {
    logic acc_en;
    logic acc_load;
    logic acc_sub;
  } mac_ctl_t;

endpackage

FILE: rtl/cascaded_biquad_iir_filter.sv
// Flow: a sample item runs through each enabled section in turn and then the output stage.
// in_stall stays high from acceptance until the result is loaded, so no new item is taken
// meanwhile; a coefficient item is taken only while idle. The single shared MAC and the one
// read port of the coefficient memory make each section a sequence of phases.
// Reset: valid bits of both memories clear at once, so coefficients read as the built-in
// table and delays as zero; there is no clearing pass. Only control registers are reset.
`include "cascaded_biquad_iir_filter_assert.svh"

module cascaded_biquad_iir_filter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  cbq_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output cbq_pkg::out_item_t                out_data,
  input  logic                              cfg_write,
  input  logic [cbq_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [cbq_pkg::CFG_DW-1:0]        cfg_data
);

  localparam int SW      = cbq_pkg::SAMPLE_WIDTH;
  localparam int WIDE_W  = 48;
  localparam int DLY_DEP = 2 ** cbq_pkg::DLY_AW;
  localparam int PH_W    = 3;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state;

  // Configuration registers.
  logic [cbq_pkg::CNT_W-1:0] sections_in_use;
  logic signed [SW-1:0]      out_min;
  logic signed [SW-1:0]      out_max;

  // Sequencer.
  logic [PH_W-1:0]               ph;
  logic [cbq_pkg::SEC_W-1:0]     sec;
  logic [cbq_pkg::CNT_W-1:0]     nsec;
  logic [cbq_pkg::COEF_AW-1:0]   coef_base;
  logic signed [cbq_pkg::DATA_W-1:0] cur;

  logic in_accept;
  logic run;
  logic last_sec;
  logic [cbq_pkg::CNT_W-1:0] n_req;

  // Coefficient memory.
  logic signed [cbq_pkg::COEF_W-1:0] coef_mem [cbq_pkg::NCOEF];
  logic [cbq_pkg::NCOEF-1:0]         coef_valid;
  logic                              coef_we;
  logic [cbq_pkg::COEF_AW-1:0]       coef_waddr;
  logic [cbq_pkg::COEF_AW-1:0]       coef_raddr;
  logic [cbq_pkg::COEF_AW-1:0]       coef_slot;
  logic signed [cbq_pkg::COEF_W-1:0] coef_mem_q;
  logic signed [cbq_pkg::COEF_W-1:0] coef_tab_q;
  logic                              coef_valid_q;
  logic signed [cbq_pkg::COEF_W-1:0] coef_rd;

  // Delay memory: x1, x2, y1, y2 per section.
  logic signed [cbq_pkg::DATA_W-1:0] dly_mem [DLY_DEP];
  logic [DLY_DEP-1:0]                dly_valid;
  logic                              dly_we;
  logic                              dly_re;
  logic [1:0]                        dly_rslot;
  logic [1:0]                        dly_wslot;
  logic [cbq_pkg::DLY_AW-1:0]        dly_raddr;
  logic [cbq_pkg::DLY_AW-1:0]        dly_waddr;
  logic signed [cbq_pkg::DATA_W-1:0] dly_wdata;
  logic signed [cbq_pkg::DATA_W-1:0] dly_mem_q;
  logic                              dly_valid_q;
  logic signed [cbq_pkg::DATA_W-1:0] dly_rd;

  // MAC.
  cbq_pkg::mac_ctl_t                 mac_ctl;
  logic signed [cbq_pkg::DATA_W-1:0] operand;
  logic signed [cbq_pkg::DATA_W-1:0] sec_y;

  // Sample conversion and output clamp.
  logic signed [WIDE_W-1:0] x_wide;
  logic signed [WIDE_W-1:0] v_wide;
  logic                     below;
  logic                     above;
  logic                     out_load;
  cbq_pkg::out_item_t       out_next;

  assign run       = (state == S_RUN);
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign last_sec  = ((cbq_pkg::CNT_W'(sec) + cbq_pkg::CNT_W'(1)) == nsec);
  assign n_req     = (sections_in_use > cbq_pkg::CNT_W'(cbq_pkg::NUM_SECTIONS)) ?
                     cbq_pkg::CNT_W'(cbq_pkg::NUM_SECTIONS) : sections_in_use;

  // Q4.x sample widened to Q15.16.
  assign x_wide = (WIDE_W'(in_data.sample_in) <<< cbq_pkg::UP_SHIFT) >>> cbq_pkg::DN_SHIFT;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      sections_in_use <= cbq_pkg::SECTIONS_RESET;
      out_min         <= cbq_pkg::OUT_MIN_RESET;
      out_max         <= cbq_pkg::OUT_MAX_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cbq_pkg::CFG_SECTIONS: sections_in_use <= cfg_data[cbq_pkg::CNT_W-1:0];
        cbq_pkg::CFG_OUT_MIN:  out_min <= cfg_data[SW-1:0];
        cbq_pkg::CFG_OUT_MAX:  out_max <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  // Main sequencer: eight phases per section.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ph    <= '0;
      sec   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept && (in_data.operation == cbq_pkg::OP_FILTER)) begin
            ph    <= '0;
            sec   <= '0;
            state <= (n_req == '0) ? S_FIN : S_RUN;
          end
        end
        S_RUN: begin
          ph <= ph + PH_W'(1);
          if (ph == PH_W'(7)) begin
            if (last_sec) begin
              state <= S_FIN;
            end else begin
              sec <= sec + cbq_pkg::SEC_W'(1);
            end
          end
        end
        S_FIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Sample datapath registers.
  always_ff @(posedge clk) begin
    if (in_accept && (in_data.operation == cbq_pkg::OP_FILTER)) begin
      cur       <= x_wide[cbq_pkg::DATA_W-1:0];
      nsec      <= n_req;
      coef_base <= '0;
    end else if (run && (ph == PH_W'(7))) begin
      cur       <= sec_y;
      coef_base <= coef_base + cbq_pkg::COEF_AW'(cbq_pkg::COEF_SLOTS);
    end
  end

  // Read order per section is b0, b2/x2, b1/x1, a2/y2, a1/y1, so every delay is
  // read before the write that shifts it.
  always_comb begin
    unique case (ph)
      PH_W'(1): begin coef_slot = cbq_pkg::SLOT_B2; dly_rslot = cbq_pkg::DLY_X2; end
      PH_W'(2): begin coef_slot = cbq_pkg::SLOT_B1; dly_rslot = cbq_pkg::DLY_X1; end
      PH_W'(3): begin coef_slot = cbq_pkg::SLOT_A2; dly_rslot = cbq_pkg::DLY_Y2; end
      PH_W'(4): begin coef_slot = cbq_pkg::SLOT_A1; dly_rslot = cbq_pkg::DLY_Y1; end
      default:  begin coef_slot = cbq_pkg::SLOT_B0; dly_rslot = cbq_pkg::DLY_X1; end
    endcase
  end

  assign coef_raddr = coef_base + coef_slot;
  assign dly_raddr  = {sec, dly_rslot};
  assign dly_re     = run && (ph >= PH_W'(1)) && (ph <= PH_W'(4));

  // Delay shifts: x2 gets old x1, x1 gets x0, y2 gets old y1, y1 gets the result.
  always_comb begin
    dly_we    = 1'b0;
    dly_wslot = cbq_pkg::DLY_X1;
    dly_wdata = dly_rd;
    if (run) begin
      unique case (ph)
        PH_W'(3): begin dly_we = 1'b1; dly_wslot = cbq_pkg::DLY_X2; end
        PH_W'(4): begin dly_we = 1'b1; dly_wslot = cbq_pkg::DLY_X1; dly_wdata = cur; end
        PH_W'(5): begin dly_we = 1'b1; dly_wslot = cbq_pkg::DLY_Y2; end
        PH_W'(7): begin dly_we = 1'b1; dly_wslot = cbq_pkg::DLY_Y1; dly_wdata = sec_y; end
        default: ;
      endcase
    end
  end

  assign dly_waddr = {sec, dly_wslot};

  // Coefficient memory: written by coefficient items, read once per cycle.
  assign coef_we    = in_accept && (in_data.operation == cbq_pkg::OP_COEF) &&
                      (in_data.coef_index < cbq_pkg::COEF_IDX_W'(cbq_pkg::NCOEF));
  assign coef_waddr = in_data.coef_index[cbq_pkg::COEF_AW-1:0];

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= in_data.coef_value;
    end
    coef_mem_q   <= coef_mem[coef_raddr];
    coef_tab_q   <= cbq_pkg::COEF_INIT[coef_raddr];
    coef_valid_q <= coef_valid[coef_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_valid <= '0;
    end else if (coef_we) begin
      coef_valid[coef_waddr] <= 1'b1;
    end
  end

  assign coef_rd = coef_valid_q ? coef_mem_q : coef_tab_q;

  // Delay memory.
  always_ff @(posedge clk) begin
    if (dly_we) begin
      dly_mem[dly_waddr] <= dly_wdata;
    end
    dly_mem_q   <= dly_mem[dly_raddr];
    dly_valid_q <= dly_valid[dly_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dly_valid <= '0;
    end else if (dly_we) begin
      dly_valid[dly_waddr] <= 1'b1;
    end
  end

  assign dly_rd = dly_valid_q ? dly_mem_q : '0;

  // Operand of the product formed this cycle: x0 first, then the delay read.
  assign operand = (ph == PH_W'(1)) ? cur : dly_rd;

  // Accumulator: load b0 term, add b terms, subtract a terms.
  assign mac_ctl.acc_en   = run && (ph >= PH_W'(2)) && (ph <= PH_W'(6));
  assign mac_ctl.acc_load = (ph == PH_W'(2));
  assign mac_ctl.acc_sub  = (ph == PH_W'(5)) || (ph == PH_W'(6));

  cbq_mac u_mac (
    .clk     (clk),
    .coef    (coef_rd),
    .operand (operand),
    .ctl     (mac_ctl),
    .y       (sec_y)
  );

  // Back to the sample format and clamp.
  assign v_wide = (WIDE_W'(cur) <<< cbq_pkg::DN_SHIFT) >>> cbq_pkg::UP_SHIFT;
  assign below  = v_wide < WIDE_W'(out_min);
  assign above  = v_wide > WIDE_W'(out_max);

  always_comb begin
    if (below) begin
      out_next.sample_out = out_min;
    end else if (above) begin
      out_next.sample_out = out_max;
    end else begin
      out_next.sample_out = v_wide[SW-1:0];
    end
    out_next.clipped = below || above;
  end

  // Output register parts the result from the next item.
  assign out_load = (state == S_FIN) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

  // A delay entry is never rewritten in the cycle it is read for this section.
  `CBQ_ASSERT_IMPL(a_dly_no_overlap, dly_we && dly_re, dly_waddr != dly_raddr,
                   "delay write and read hit the same entry")
  // Coefficients change only between items.
  `CBQ_ASSERT_IMPL(a_coef_write_idle, coef_we, $past(state) != S_RUN || state == S_IDLE,
                   "coefficient write while filtering")
  // Finishing the last section always leads to the output stage.
  `CBQ_ASSERT_NEXT(a_last_to_fin, run && (ph == PH_W'(7)) && last_sec, state == S_FIN,
                   "last section did not hand over to the output stage")
  // A new result only appears from the output stage.
  `CBQ_ASSERT_IMPL(a_out_from_fin, $rose(out_valid), $past(state == S_FIN),
                   "result appeared outside the output stage")

endmodule

FILE: rtl/cbq_mac.sv
module cbq_mac (
  input  logic                              clk,
  input  logic signed [cbq_pkg::COEF_W-1:0] coef,
  input  logic signed [cbq_pkg::DATA_W-1:0] operand,
  input  cbq_pkg::mac_ctl_t                 ctl,
  output logic signed [cbq_pkg::DATA_W-1:0] y
);

  localparam int Q_W = cbq_pkg::ACC_W - cbq_pkg::COEF_FRAC;

  logic signed [cbq_pkg::PROD_W-1:0] prod;
  logic signed [cbq_pkg::ACC_W-1:0]  acc;
  logic signed [cbq_pkg::ACC_W-1:0]  prod_ext;
  logic signed [Q_W-1:0]             q;
  logic                              q_ovf;

  // One product per cycle, registered before the accumulator.
  always_ff @(posedge clk) begin
    prod <= coef * operand;
  end

  assign prod_ext = cbq_pkg::ACC_W'(prod);

  // The exact sum of all five products is kept, so one floor at the end suffices.
  always_ff @(posedge clk) begin
    if (ctl.acc_en) begin
      if (ctl.acc_load) begin
        acc <= prod_ext;
      end else if (ctl.acc_sub) begin
        acc <= acc - prod_ext;
      end else begin
        acc <= acc + prod_ext;
      end
    end
  end

  // Floor to Q15.16 and saturate to the signed 32-bit range.
  assign q     = Q_W'(acc >>> cbq_pkg::COEF_FRAC);
  assign q_ovf = (q[Q_W-1:cbq_pkg::DATA_W-1] != '0) && (q[Q_W-1:cbq_pkg::DATA_W-1] != '1);

  always_comb begin
    if (!q_ovf) begin
      y = q[cbq_pkg::DATA_W-1:0];
    end else if (q[Q_W-1]) begin
      y = {1'b1, {(cbq_pkg::DATA_W-1){1'b0}}};
    end else begin
      y = {1'b0, {(cbq_pkg::DATA_W-1){1'b1}}};
    end
  end

endmodule
